// ===== rtl/phe_pkg.sv =====
// Package with shared types, codes and the derivative weight function of the polynomial evaluator.
package phe_pkg;

  localparam int unsigned NUM_COEF  = 8;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned WGT_W     = 6;
  localparam int unsigned ACT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_VALUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_D1    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_D2    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BAD   = 2'd3;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_NOP,
    OP_MUL,
    OP_ACC,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOSTART,
    C_BAD,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t        op;
    cond_t      cond;
    logic [2:0] target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic bad;
    logic more;
  } flags_t;

  // Falling factorial k*(k-1)*...*(k-m+1) for derivative order m.
  function automatic logic [WGT_W-1:0] weight(input logic [IDX_W-1:0] k,
                                              input logic [ACT_W-1:0] m);
    logic [WGT_W-1:0] kw;
    logic [WGT_W-1:0] km1;
    kw  = WGT_W'(k);
    km1 = WGT_W'(k - IDX_W'(1));
    case (m)
      ACT_VALUE: weight = WGT_W'(1);
      ACT_D1:    weight = kw;
      ACT_D2:    weight = WGT_W'(kw * km1);
      default:   weight = '0;
    endcase
  endfunction

endpackage

// ===== rtl/phe_seq.sv =====
// Microcode sequencer: program counter, control store and conditional jumps.
module phe_seq
  import phe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctl_t   ctl
);

  localparam logic [2:0] PC_IDLE  = 3'd0;
  localparam logic [2:0] PC_CHECK = 3'd1;
  localparam logic [2:0] PC_MUL   = 3'd2;
  localparam logic [2:0] PC_ACC   = 3'd3;
  localparam logic [2:0] PC_DONE  = 3'd4;

  logic [2:0] pc_r;
  logic [2:0] pc_nxt;
  logic       take;

  always_comb begin
    case (pc_r)
      PC_IDLE:  ctl = '{op: OP_IDLE, cond: C_NOSTART, target: PC_IDLE};
      PC_CHECK: ctl = '{op: OP_NOP,  cond: C_BAD,     target: PC_DONE};
      PC_MUL:   ctl = '{op: OP_MUL,  cond: C_NEXT,    target: PC_ACC};
      PC_ACC:   ctl = '{op: OP_ACC,  cond: C_MORE,    target: PC_MUL};
      PC_DONE:  ctl = '{op: OP_DONE, cond: C_ALWAYS,  target: PC_IDLE};
      default:  ctl = '{op: OP_NOP,  cond: C_ALWAYS,  target: PC_IDLE};
    endcase
  end

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:  take = 1'b1;
      C_NOSTART: take = !flags.start;
      C_BAD:     take = flags.bad;
      C_MORE:    take = flags.more;
      default:   take = 1'b0;
    endcase
    pc_nxt = take ? ctl.target : pc_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== rtl/polynomial_horner_eval_with_derivatives.sv =====
// Top level: Horner polynomial evaluator with first and second derivatives, Q16.16 in, Q32.16 out.
// Each Horner step uses the shared multiply-accumulate: split product (MUL), then add (ACC).
// With n = DEGREE - order + 1 steps, a transaction runs CHECK, n MUL/ACC pairs, then DONE;
// an undefined order goes from CHECK to DONE. A new one is accepted only back in IDLE.
// The receiver cannot stall: out_valid is high for exactly one cycle per transaction.
// Synchronous active-low reset returns the sequencer to idle and clears all coefficients to 0.
module polynomial_horner_eval_with_derivatives
  import phe_pkg::*;
#(
  parameter int unsigned DEGREE = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [COEF_W-1:0] in_point,
  output logic                     out_valid,
  output logic signed [ACC_W-1:0]  out_result,
  output logic                     out_overflow,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  localparam logic [IDX_W-1:0] DEG_K = IDX_W'(DEGREE);
  localparam int unsigned PLO_W = 2 * COEF_W + 1;
  localparam int unsigned PHI_W = ACC_W;
  localparam int unsigned TRM_W = WGT_W + 1 + COEF_W;
  localparam int unsigned SUM_W = 66;

  ctl_t   ctl;
  flags_t flags;

  logic signed [COEF_W-1:0] coef_r [NUM_COEF];
  logic [ACT_W-1:0]         m_r;
  logic signed [COEF_W-1:0] x_r;
  logic [IDX_W-1:0]         k_r;
  logic signed [ACC_W-1:0]  b_r;
  logic                     ovf_r;
  logic signed [PLO_W-1:0]  plo_r;
  logic signed [PHI_W-1:0]  phi_r;
  logic signed [TRM_W-1:0]  term_r;

  logic                     accept;
  logic signed [SUM_W-1:0]  sum;
  logic                     over;
  logic                     under;
  logic signed [ACC_W-1:0]  clamped;

  phe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  assign busy   = (ctl.op != OP_IDLE);
  assign accept = start && !busy;

  always_comb begin
    flags.start = start;
    flags.bad   = (m_r == ACT_BAD) || (IDX_W'(m_r) > DEG_K);
    flags.more  = (k_r != IDX_W'(m_r));
  end

  always_comb begin
    sum = SUM_W'($signed({phi_r, 16'b0})) + SUM_W'($signed(plo_r[PLO_W-1:16]))
        + SUM_W'(term_r);
    over  = !sum[SUM_W-1] && (|sum[SUM_W-2:ACC_W-1]);
    under = sum[SUM_W-1] && !(&sum[SUM_W-2:ACC_W-1]);
    if (over) begin
      clamped = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (under) begin
      clamped = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      clamped = sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we) begin
      coef_r[IDX_W'(NUM_COEF - 1) - cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_r   <= in_action;
      x_r   <= in_point;
      k_r   <= DEG_K;
      b_r   <= '0;
      ovf_r <= 1'b0;
    end
    case (ctl.op)
      OP_MUL: begin
        plo_r  <= $signed({1'b0, b_r[COEF_W-1:0]}) * x_r;
        phi_r  <= $signed(b_r[ACC_W-1:COEF_W]) * x_r;
        term_r <= $signed({1'b0, weight(k_r, m_r)}) * coef_r[k_r];
      end
      OP_ACC: begin
        b_r   <= clamped;
        ovf_r <= ovf_r | over | under;
        if (flags.more) begin
          k_r <= k_r - IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid    = (ctl.op == OP_DONE);
  assign out_result   = b_r;
  assign out_overflow = ovf_r;

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transaction did not start");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && m_r == ACT_BAD) |-> (out_result == '0 && !out_overflow))
    else $error("undefined action gave a non-zero result");

  a_done_next_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("sequencer did not return to idle after the result");

endmodule

// ===== tb/polynomial_horner_eval_with_derivatives_test.sv =====
// Self-checking testbench for the Horner polynomial evaluator with first and second derivatives.
module polynomial_horner_eval_with_derivatives_test;
  import phe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEGREE = 7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_BLOCK = 40;
  localparam int RANDOM_BLOCKS = 12;
  localparam int MAX_PRINTED = 50;

  localparam logic [IDX_W-1:0] REG_COEF_X7 = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_X6 = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_X5 = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_X4 = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_X3 = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_X2 = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_X1 = 3'd6;
  localparam logic [IDX_W-1:0] REG_COEF_X0 = 3'd7;

  localparam logic signed [COEF_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [COEF_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [COEF_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;

  localparam logic signed [63:0] ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_LO = -ACC_HI - 64'sd1;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic signed [COEF_W-1:0] point;
  } query_t;

  typedef struct {
    logic signed [ACC_W-1:0] result;
    logic                    overflow;
  } horner_eval_t;

  typedef logic signed [COEF_W-1:0] coef_set_t [NUM_COEF];

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [ACT_W-1:0]         in_action = ACT_VALUE;
  logic signed [COEF_W-1:0] in_point = '0;
  logic                     out_valid;
  logic signed [ACC_W-1:0]  out_result;
  logic                     out_overflow;
  logic                     cfg_we = 1'b0;
  logic [IDX_W-1:0]         cfg_index = REG_COEF_X7;
  logic [COEF_W-1:0]        cfg_data = '0;

  logic signed [COEF_W-1:0] coef_by_power [NUM_COEF];
  query_t                   pending_queries [$];
  horner_eval_t             expected_evals [$];
  int                       mismatch_count = 0;
  int                       sender_idle_pct = 32;
  int                       cycle_count = 0;
  logic                     drain_hold = 1'b0;
  query_t                   next_query;
  horner_eval_t             issued_eval;
  horner_eval_t             awaited_eval;

  polynomial_horner_eval_with_derivatives #(.DEGREE(DEGREE)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_point     (in_point),
    .out_valid    (out_valid),
    .out_result   (out_result),
    .out_overflow (out_overflow),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint falling_factorial(input int k, input int m);
    longint w;
    w = 1;
    for (int i = 0; i < m; i++) w = w * (k - i);
    return w;
  endfunction

  function automatic horner_eval_t evaluate_poly(input logic [ACT_W-1:0] act,
                                                 input logic signed [COEF_W-1:0] x);
    horner_eval_t       r;
    logic signed [63:0] acc;
    logic signed [63:0] term;
    logic signed [63:0] xw;
    logic signed [63:0] wk;
    logic signed [95:0] prod;
    int                 m;
    int                 k;
    r.result   = '0;
    r.overflow = 1'b0;
    if (act == ACT_BAD || int'(DEGREE) < int'(act)) return r;
    m   = int'(act);
    acc = '0;
    xw  = x;
    for (k = DEGREE; k >= m; k--) begin
      wk   = falling_factorial(k, m);
      term = wk * coef_by_power[k];
      prod = acc * xw;
      acc  = term + 64'(prod >>> 16);
      if (acc > ACC_HI) begin
        acc        = ACC_HI;
        r.overflow = 1'b1;
      end else if (acc < ACC_LO) begin
        acc        = ACC_LO;
        r.overflow = 1'b1;
      end
    end
    r.result = acc[ACC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        issued_eval = evaluate_poly(in_action, in_point);
        expected_evals.push_back(issued_eval);
      end
      if (!start || !busy) begin
        if (drain_hold) begin
          if (expected_evals.size() == 0) drain_hold = 1'b0;
          start <= 1'b0;
        end else if (pending_queries.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_query = pending_queries.pop_front();
          start     <= 1'b1;
          in_action <= next_query.action;
          in_point  <= next_query.point;
          if ($urandom_range(99) == 0) drain_hold = 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_evals.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction outstanding", out_result));
      end else begin
        awaited_eval = expected_evals.pop_front();
        if (out_result !== awaited_eval.result)
          report_mismatch($sformatf("result %0d, expected %0d", out_result, awaited_eval.result));
        if (out_overflow !== awaited_eval.overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b",
                                    out_overflow, awaited_eval.overflow));
      end
    end
  end

  task automatic wait_idle();
    while (!(pending_queries.size() == 0 && !start && expected_evals.size() == 0 && !busy))
      @(negedge clk);
  endtask

  task automatic load_coefs(input coef_set_t vals);
    wait_idle();
    for (int i = REG_COEF_X7; i <= REG_COEF_X0; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data  <= vals[i];
      coef_by_power[NUM_COEF-1-i] = vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_query(input logic [ACT_W-1:0] act, input logic signed [COEF_W-1:0] pt);
    query_t q;
    q.action = act;
    q.point  = pt;
    pending_queries.push_back(q);
  endtask

  function automatic logic signed [COEF_W-1:0] random_point();
    int sel;
    sel = $urandom_range(9);
    if (sel <= 5) return $signed(32'($urandom_range(32'h40000))) - 32'sh20000;
    if (sel <= 8) return $signed(32'($urandom));
    case ($urandom_range(6))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return Q_ONE;
      4:       return Q_NEG_ONE;
      5:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] random_action();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return ACT_BAD;
    case (sel % 3)
      0:       return ACT_VALUE;
      1:       return ACT_D1;
      default: return ACT_D2;
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] random_coef(input int kind);
    if ($urandom_range(9) == 0) return $urandom_range(1) ? Q_MAX : Q_MIN;
    if (kind == 0) return $signed(32'($urandom));
    return $signed(32'($urandom_range(32'h80000))) - 32'sh40000;
  endfunction

  initial begin
    coef_set_t vals;
    int        kind;
    int        leading_zeros;
    for (int i = 0; i < NUM_COEF; i++) coef_by_power[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_query(ACT_VALUE, Q_MAX);
    queue_query(ACT_D1, Q_MAX);
    queue_query(ACT_D2, Q_MAX);
    queue_query(ACT_BAD, Q_MAX);

    for (int i = 0; i < NUM_COEF; i++) vals[i] = Q_MAX;
    load_coefs(vals);
    queue_query(ACT_VALUE, Q_MAX);
    queue_query(ACT_D1, Q_MAX);
    queue_query(ACT_D2, Q_MAX);
    queue_query(ACT_VALUE, Q_MIN);
    queue_query(ACT_D1, Q_MIN);
    queue_query(ACT_D2, Q_MIN);

    for (int i = 0; i < NUM_COEF; i++) vals[i] = Q_MIN;
    load_coefs(vals);
    queue_query(ACT_VALUE, Q_ONE);
    queue_query(ACT_D1, Q_ONE);
    queue_query(ACT_D2, Q_ONE);

    // Only the linear and constant terms are set, so the effective degree drops to one.
    for (int i = 0; i < NUM_COEF; i++) vals[i] = '0;
    vals[REG_COEF_X1] = 32'sh0001_8000;
    vals[REG_COEF_X0] = -32'sh0002_0000;
    load_coefs(vals);
    queue_query(ACT_VALUE, -32'sh0001_8000);
    queue_query(ACT_D1, -32'sh0001_8000);
    queue_query(ACT_D2, -32'sh0001_8000);
    queue_query(ACT_VALUE, -32'sd1);
    queue_query(ACT_VALUE, 32'sd1);
    queue_query(ACT_VALUE, '0);

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      kind          = $urandom_range(3);
      leading_zeros = $urandom_range(1) ? $urandom_range(NUM_COEF - 1) : 0;
      for (int i = 0; i < NUM_COEF; i++) vals[i] = (i < leading_zeros) ? '0 : random_coef(kind);
      load_coefs(vals);
      sender_idle_pct = (blk < RANDOM_BLOCKS / 3) ? 32 : (blk < 2 * RANDOM_BLOCKS / 3) ? 62 : 0;
      for (int n = 0; n < ITEMS_PER_BLOCK; n++) queue_query(random_action(), random_point());
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
